// ----- design/assert_macros.svh -----
// Assertion macros used by the RTL of the ancestor engine.
// Depends on nothing; each macro takes a label, clock, reset and expressions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, skipped while reset is low.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// Next-cycle implication, skipped while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ----- design/tlca_pkg.sv -----
// Types and codes of the tree ancestor engine.
// Used by the top level; depends on nothing.
package tlca_pkg;

    localparam int NODE_W  = 16;
    localparam int DEPTH_W = 16;
    localparam int LEN_W   = 17;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_QUERY  = 1'b1;

    typedef struct packed {
        logic              func;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
    } item_t;

    typedef struct packed {
        logic [NODE_W-1:0] common_ancestor;
        logic [LEN_W-1:0]  path_length;
    } result_t;

endpackage

// ----- design/tlca_ram.sv -----
// Generic synchronous RAM: one write port, two read ports, registered reads.
// Depends on nothing.
module tlca_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ----- design/tree_lca_binary_lifting_unit.sv -----
// Tree ancestor engine: binary-lifting depth and ancestor tables in RAM.
// Depends on tlca_pkg, tlca_ram and assert_macros.svh.
//
// Usage:
//   Drive item and raise start; the transfer happens at a clock edge with
//   start high and busy low. func = insert stores node_a under parent node_b
//   (parent first, root under node 0); func = query looks up node_a, node_b.
//   An insert gives no result. A query gives one result: result_valid is
//   high for exactly one cycle with result holding the lowest common ancestor
//   and the path length in edges. The receiver cannot stall the block.
// Sequence:
//   Insert: read the parent depth, write the depth, then ancestors per level.
//   Query: read both depths, lift the deeper node, compare; if unequal, lift
//   both nodes and take the parent; then read the LCA depth. Each lifting
//   step waits for its registered read of the ancestor RAM.
// Reset:
//   rst_n clears the control state only. Table contents stay undefined;
//   node 0 and nodes at or beyond NODE_COUNT always read depth 0 and
//   ancestor 0. The block accepts an item in the first cycle after reset.
`include "assert_macros.svh"

module tree_lca_binary_lifting_unit
    import tlca_pkg::*;
#(
    parameter int NODE_COUNT = 65536,
    parameter int LEVELS     = 16
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  item_t   item,
    output logic    result_valid,
    output result_t result
);

    localparam int NODE_DEPTH = (NODE_COUNT < 65536) ? NODE_COUNT : 65536;
    localparam int AW         = $clog2(NODE_DEPTH);
    localparam int LW         = $clog2(LEVELS);
    localparam int ANC_DEPTH  = NODE_DEPTH * (2 ** LW);
    localparam int DW         = (LEVELS > DEPTH_W) ? LEVELS : DEPTH_W;
    localparam logic [LW-1:0] J_TOP = LW'(LEVELS - 1);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_I_D     = 4'd1;
    localparam logic [3:0] S_I_DW    = 4'd2;
    localparam logic [3:0] S_I_RD    = 4'd3;
    localparam logic [3:0] S_I_WR    = 4'd4;
    localparam logic [3:0] S_Q_D     = 4'd5;
    localparam logic [3:0] S_Q_DW    = 4'd6;
    localparam logic [3:0] S_Q_LIFT  = 4'd7;
    localparam logic [3:0] S_Q_LIFTW = 4'd8;
    localparam logic [3:0] S_Q_CMP   = 4'd9;
    localparam logic [3:0] S_Q_BL    = 4'd10;
    localparam logic [3:0] S_Q_BLW   = 4'd11;
    localparam logic [3:0] S_Q_P     = 4'd12;
    localparam logic [3:0] S_Q_PW    = 4'd13;
    localparam logic [3:0] S_Q_LD    = 4'd14;
    localparam logic [3:0] S_Q_LDW   = 4'd15;

    function automatic logic in_range(input logic [NODE_W-1:0] n);
        return 32'(n) < NODE_COUNT;
    endfunction

    function automatic logic node_ok(input logic [NODE_W-1:0] n);
        return (n != '0) && in_range(n);
    endfunction

    logic [3:0]         state_reg, state_next;
    item_t              item_reg, item_next;
    logic [NODE_W-1:0]  u_reg, u_next;
    logic [NODE_W-1:0]  v_reg, v_next;
    logic [LW-1:0]      j_reg, j_next;
    logic [LEVELS-1:0]  diff_reg, diff_next;
    logic [LEN_W-1:0]   sum_reg, sum_next;
    result_t            result_reg, result_next;
    logic               result_valid_reg, result_valid_next;

    logic                 dep_we;
    logic [AW-1:0]        dep_waddr, dep_raddr_a, dep_raddr_b;
    logic [DEPTH_W-1:0]   dep_wdata, dep_rdata_a, dep_rdata_b;
    logic                 anc_we;
    logic [AW+LW-1:0]     anc_waddr, anc_raddr_a, anc_raddr_b;
    logic [NODE_W-1:0]    anc_wdata, anc_rdata_a, anc_rdata_b;

    logic [NODE_W-1:0]  anc_u_val, anc_v_val;
    logic [DEPTH_W-1:0] da_q, db_q, diff_full, parent_depth, new_depth, lca_depth;
    logic [DW-1:0]      diff_wide;
    logic [LEN_W-1:0]   twice_depth;

    tlca_ram #(
        .WIDTH (DEPTH_W),
        .DEPTH (NODE_DEPTH)
    ) u_depth_ram (
        .clk     (clk),
        .we      (dep_we),
        .waddr   (dep_waddr),
        .wdata   (dep_wdata),
        .raddr_a (dep_raddr_a),
        .rdata_a (dep_rdata_a),
        .raddr_b (dep_raddr_b),
        .rdata_b (dep_rdata_b)
    );

    tlca_ram #(
        .WIDTH (NODE_W),
        .DEPTH (ANC_DEPTH)
    ) u_anc_ram (
        .clk     (clk),
        .we      (anc_we),
        .waddr   (anc_waddr),
        .wdata   (anc_wdata),
        .raddr_a (anc_raddr_a),
        .rdata_a (anc_rdata_a),
        .raddr_b (anc_raddr_b),
        .rdata_b (anc_rdata_b)
    );

    assign anc_u_val    = node_ok(u_reg) ? anc_rdata_a : '0;
    assign anc_v_val    = node_ok(v_reg) ? anc_rdata_b : '0;
    assign da_q         = node_ok(item_reg.node_a) ? dep_rdata_a : '0;
    assign db_q         = node_ok(item_reg.node_b) ? dep_rdata_b : '0;
    assign diff_full    = (da_q < db_q) ? (db_q - da_q) : (da_q - db_q);
    assign diff_wide    = DW'(diff_full);
    assign parent_depth = node_ok(item_reg.node_b) ? dep_rdata_a : '0;
    assign new_depth    = (parent_depth == '1) ? parent_depth : parent_depth + 1'b1;
    assign lca_depth    = node_ok(u_reg) ? dep_rdata_a : '0;
    assign twice_depth  = {lca_depth, 1'b0};

    always_comb
    begin
        state_next        = state_reg;
        item_next         = item_reg;
        u_next            = u_reg;
        v_next            = v_reg;
        j_next            = j_reg;
        diff_next         = diff_reg;
        sum_next          = sum_reg;
        result_next       = result_reg;
        result_valid_next = 1'b0;
        dep_we            = 1'b0;
        dep_waddr         = '0;
        dep_wdata         = '0;
        dep_raddr_a       = '0;
        dep_raddr_b       = '0;
        anc_we            = 1'b0;
        anc_waddr         = '0;
        anc_wdata         = '0;
        anc_raddr_a       = '0;
        anc_raddr_b       = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    item_next  = item;
                    state_next = (item.func == FUNC_QUERY) ? S_Q_D : S_I_D;
                end
            end
            S_I_D:
            begin
                dep_raddr_a = item_reg.node_b[AW-1:0];
                if ((item_reg.node_a == '0) || !in_range(item_reg.node_a)
                    || !in_range(item_reg.node_b))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_I_DW;
                end
            end
            S_I_DW:
            begin
                dep_we     = 1'b1;
                dep_waddr  = item_reg.node_a[AW-1:0];
                dep_wdata  = new_depth;
                anc_we     = 1'b1;
                anc_waddr  = {item_reg.node_a[AW-1:0], LW'(0)};
                anc_wdata  = item_reg.node_b;
                u_next     = item_reg.node_b;
                j_next     = LW'(1);
                state_next = S_I_RD;
            end
            S_I_RD:
            begin
                anc_raddr_a = {u_reg[AW-1:0], j_reg - 1'b1};
                state_next  = S_I_WR;
            end
            S_I_WR:
            begin
                anc_we    = 1'b1;
                anc_waddr = {item_reg.node_a[AW-1:0], j_reg};
                anc_wdata = anc_u_val;
                u_next    = anc_u_val;
                if (j_reg == J_TOP)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_I_RD;
                end
            end
            S_Q_D:
            begin
                dep_raddr_a = item_reg.node_a[AW-1:0];
                dep_raddr_b = item_reg.node_b[AW-1:0];
                state_next  = S_Q_DW;
            end
            S_Q_DW:
            begin
                if (da_q < db_q)
                begin
                    u_next = item_reg.node_b;
                    v_next = item_reg.node_a;
                end
                else
                begin
                    u_next = item_reg.node_a;
                    v_next = item_reg.node_b;
                end
                sum_next   = {1'b0, da_q} + {1'b0, db_q};
                diff_next  = diff_wide[LEVELS-1:0];
                j_next     = J_TOP;
                state_next = S_Q_LIFT;
            end
            S_Q_LIFT:
            begin
                anc_raddr_a = {u_reg[AW-1:0], j_reg};
                if (diff_reg[j_reg])
                begin
                    state_next = S_Q_LIFTW;
                end
                else if (j_reg == '0)
                begin
                    state_next = S_Q_CMP;
                end
                else
                begin
                    j_next = j_reg - 1'b1;
                end
            end
            S_Q_LIFTW:
            begin
                u_next = anc_u_val;
                if (j_reg == '0)
                begin
                    state_next = S_Q_CMP;
                end
                else
                begin
                    j_next     = j_reg - 1'b1;
                    state_next = S_Q_LIFT;
                end
            end
            S_Q_CMP:
            begin
                j_next     = J_TOP;
                state_next = (u_reg == v_reg) ? S_Q_LD : S_Q_BL;
            end
            S_Q_BL:
            begin
                anc_raddr_a = {u_reg[AW-1:0], j_reg};
                anc_raddr_b = {v_reg[AW-1:0], j_reg};
                state_next  = S_Q_BLW;
            end
            S_Q_BLW:
            begin
                if (anc_u_val != anc_v_val)
                begin
                    u_next = anc_u_val;
                    v_next = anc_v_val;
                end
                if (j_reg == '0)
                begin
                    state_next = S_Q_P;
                end
                else
                begin
                    j_next     = j_reg - 1'b1;
                    state_next = S_Q_BL;
                end
            end
            S_Q_P:
            begin
                anc_raddr_a = {u_reg[AW-1:0], LW'(0)};
                state_next  = S_Q_PW;
            end
            S_Q_PW:
            begin
                u_next     = anc_u_val;
                state_next = S_Q_LD;
            end
            S_Q_LD:
            begin
                dep_raddr_a = u_reg[AW-1:0];
                state_next  = S_Q_LDW;
            end
            S_Q_LDW:
            begin
                result_next.common_ancestor = u_reg;
                result_next.path_length     = (sum_reg >= twice_depth) ?
                                              (sum_reg - twice_depth) : '0;
                result_valid_next           = 1'b1;
                state_next                  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        u_reg      <= u_next;
        v_reg      <= v_next;
        j_reg      <= j_next;
        diff_reg   <= diff_next;
        sum_reg    <= sum_next;
        result_reg <= result_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `ASSERT_IMPLIES(a_result_when_idle, clk, rst_n, result_valid_reg, state_reg == S_IDLE)
    `ASSERT_NEXT(a_busy_after_transfer, clk, rst_n, start && !busy, busy)
    `ASSERT_IMPLIES(a_anc_write_on_insert, clk, rst_n, anc_we, (state_reg == S_I_DW) || (state_reg == S_I_WR))
    `ASSERT_NEXT(a_result_from_last_step, clk, rst_n, state_reg == S_Q_LDW, result_valid_reg)

endmodule
